### hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the Base64 alphabet map for the word decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int WORD_BYTES_DEFAULT = 8;
    localparam int WORD_BYTES_MAX     = 8;

    // Alphabet anchors
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } b64d_sextet_t;

    // Group under assembly: sextet 0 sits in acc[23:18]
    typedef struct packed {
        logic [23:0] acc;
        logic [1:0]  cnt;
    } b64d_group_t;

    function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
        b64d_sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        priority if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            s.value = 6'(c - CHAR_UPPER_A);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            s.value = 6'(c - CHAR_LOWER_A + 8'd26);
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            s.value = 6'(c - CHAR_DIGIT_0 + 8'd52);
        end
        else if (c == CHAR_PLUS)
        begin
            s.value = SEXTET_PLUS;
        end
        else if (c == CHAR_SLASH)
        begin
            s.value = SEXTET_SLASH;
        end
        else
        begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

### hw/rtl/b64d_in_if.sv
// ----------------------------------------------------------------------------
// b64d_in_if
// Character request channel: one raw byte and an end-of-string mark.
// ----------------------------------------------------------------------------
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

### hw/rtl/b64d_out_if.sv
// ----------------------------------------------------------------------------
// b64d_out_if
// Word request channel: one packed 64-bit data word.
// ----------------------------------------------------------------------------
interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

### hw/rtl/b64d_pack.sv
// ----------------------------------------------------------------------------
// b64d_pack
// One-character step: sextet map, group assembly, byte packing into words.
// ----------------------------------------------------------------------------
module b64d_pack #(
    parameter int WORD_BYTES = b64d_pkg::WORD_BYTES_DEFAULT,
    localparam int PEND_BYTES = (WORD_BYTES > 1) ? WORD_BYTES - 1 : 1,
    localparam int PEND_W     = 8 * PEND_BYTES
) (
    input  logic [7:0]          char_code,
    input  logic                end_of_string,
    input  b64d_pkg::b64d_group_t group_cur,
    input  logic [PEND_W-1:0]   pend_cur,
    input  logic [2:0]          pcnt_cur,
    output b64d_pkg::b64d_group_t group_next,
    output logic [PEND_W-1:0]   pend_next,
    output logic [2:0]          pcnt_next,
    output logic                emit,
    output logic [63:0]         word
);

    b64d_pkg::b64d_sextet_t sx;
    logic [23:0] acc_add;
    logic [1:0]  cnt_add;
    logic        full;
    logic [1:0]  nb;
    logic [7:0]  byte_v [3];
    logic [63:0] work;
    logic [3:0]  wcnt;

    always_comb
    begin
        sx      = b64d_pkg::sextet_of(char_code);
        acc_add = group_cur.acc;
        cnt_add = group_cur.cnt;
        if (sx.valid)
        begin
            unique case (group_cur.cnt)
                2'd0:    acc_add = group_cur.acc | {sx.value, 18'd0};
                2'd1:    acc_add = group_cur.acc | {6'd0, sx.value, 12'd0};
                2'd2:    acc_add = group_cur.acc | {12'd0, sx.value, 6'd0};
                default: acc_add = group_cur.acc | {18'd0, sx.value};
            endcase
            cnt_add = group_cur.cnt + 2'd1;
        end
        full = sx.valid && (group_cur.cnt == 2'd3);

        // bytes out this step: full group, or k-1 on a flushed partial group
        priority if (full)
            nb = 2'd3;
        else if (end_of_string && cnt_add >= 2'd2)
            nb = cnt_add - 2'd1;
        else
            nb = 2'd0;

        byte_v[0] = acc_add[23:16];
        byte_v[1] = acc_add[15:8];
        byte_v[2] = acc_add[7:0];

        work = 64'(pend_cur);
        wcnt = {1'b0, pcnt_cur};
        emit = 1'b0;
        word = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < nb)
            begin
                work[{wcnt[2:0], 3'b000} +: 8] = byte_v[i];
                wcnt = wcnt + 4'd1;
                if (wcnt >= 4'(WORD_BYTES))
                begin
                    // only the first completed word leaves in one step
                    if (!emit)
                    begin
                        word = work;
                        emit = 1'b1;
                    end
                    work = '0;
                    wcnt = 4'd0;
                end
            end
        end

        if (end_of_string)
        begin
            group_next = '0;
            pend_next  = '0;
            pcnt_next  = 3'd0;
        end
        else
        begin
            if (full)
                group_next = '0;
            else
            begin
                group_next.acc = acc_add;
                group_next.cnt = cnt_add;
            end
            pend_next = work[PEND_W-1:0];
            pcnt_next = wcnt[2:0];
        end
    end

endmodule

### hw/rtl/base64_to_word_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_to_word_decoder_core
// Base64 character stream to packed 64-bit words.
// ----------------------------------------------------------------------------
// One character is taken every cycle, with no gaps, while the word output is
// not stalled. A character sits in an input register, passes through the
// single-cycle step logic (alphabet map, group assembly, byte packing) and a
// completed word lands in the output register. Characters outside the Base64
// alphabet are skipped; the end-of-string mark flushes a partial group and
// drops an unfinished word. The output register lets the next character in
// while a word still waits.
module base64_to_word_decoder_core #(
    parameter int WORD_BYTES = b64d_pkg::WORD_BYTES_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    b64d_in_if.sink    char_in,
    b64d_out_if.source word_out
);

    localparam int PEND_BYTES = (WORD_BYTES > 1) ? WORD_BYTES - 1 : 1;
    localparam int PEND_W     = 8 * PEND_BYTES;

    logic                  s1_valid_reg, s1_valid_next;
    logic [7:0]            s1_char_reg;
    logic                  s1_eos_reg;
    b64d_pkg::b64d_group_t group_reg;
    logic [PEND_W-1:0]     pend_reg;
    logic [2:0]            pcnt_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [63:0]           out_word_reg;

    b64d_pkg::b64d_group_t group_step;
    logic [PEND_W-1:0]     pend_step;
    logic [2:0]            pcnt_step;
    logic                  emit;
    logic [63:0]           word;
    logic                  out_free;
    logic                  advance;
    logic                  take_in;

    b64d_pack #(.WORD_BYTES(WORD_BYTES)) u_pack (
        .char_code     (s1_char_reg),
        .end_of_string (s1_eos_reg),
        .group_cur     (group_reg),
        .pend_cur      (pend_reg),
        .pcnt_cur      (pcnt_reg),
        .group_next    (group_step),
        .pend_next     (pend_step),
        .pcnt_next     (pcnt_step),
        .emit          (emit),
        .word          (word)
    );

    always_comb
    begin
        out_free      = !out_valid_reg || word_out.ready;
        // a character that yields no word never waits on the output
        advance       = s1_valid_reg && (!emit || out_free);
        char_in.ready = !s1_valid_reg || advance;
        take_in       = char_in.valid && char_in.ready;

        s1_valid_next = take_in || (s1_valid_reg && !advance);

        out_valid_next = out_valid_reg && !word_out.ready;
        if (advance && emit)
            out_valid_next = 1'b1;

        word_out.valid     = out_valid_reg;
        word_out.data_word = out_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            group_reg     <= '0;
            pend_reg      <= '0;
            pcnt_reg      <= 3'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                group_reg <= group_step;
                pend_reg  <= pend_step;
                pcnt_reg  <= pcnt_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_char_reg <= char_in.char_code;
            s1_eos_reg  <= char_in.end_of_string;
        end
        if (advance && emit)
            out_word_reg <= word;
    end

    // pending bytes never reach a full word without being sent on
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pcnt_reg} < 4'(WORD_BYTES))
        else $error("pending byte count reached word size");

    // end of string leaves the decoder empty
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_eos_reg |=> group_reg == '0 && pcnt_reg == 3'd0 && pend_reg == '0)
        else $error("state not cleared after end of string");

    // a waiting word is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !word_out.ready |=> out_valid_reg && $stable(out_word_reg))
        else $error("stalled output word lost");

    // a held character is not replaced before it is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_char_reg)
            && $stable(s1_eos_reg))
        else $error("held character overwritten");

endmodule
